// ===== hw/rtl/affine_quantizer_sat_count_defines.svh =====
// assertion macros shared by the quantizer rtl
`ifndef AFFINE_QUANTIZER_SAT_COUNT_DEFINES_SVH
`define AFFINE_QUANTIZER_SAT_COUNT_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define AQSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AQSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aqsc_pkg.sv =====
// constants shared by the affine quantizer
package aqsc_pkg;

  localparam int CODE_BITS   = 16;
  localparam int COUNT_BITS  = 32;
  localparam int SAMPLE_BITS = 32;
  localparam int SCALE_BITS  = 32;
  localparam int TOTAL_BITS  = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int OUT_DATA_BITS  = 80;
  localparam int OUT_USER_BITS  = 2;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_SCALE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_POINT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_CODE   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_CODE   = 2'd3;

  // reset values of the registers
  localparam logic [SCALE_BITS-1:0]   INV_SCALE_RST  = 32'h0001_0000;
  localparam logic signed [15:0]      ZERO_POINT_RST = 16'sd0;
  localparam logic signed [15:0]      MIN_CODE_RST   = -16'sd128;
  localparam logic signed [15:0]      MAX_CODE_RST   = 16'sd127;

  // signed range of a code
  localparam logic signed [15:0] CODE_HI = 16'((32'd1 << (CODE_BITS - 1)) - 32'd1);
  localparam logic signed [15:0] CODE_LO = -CODE_HI - 16'sd1;

  // user bit positions on the result side
  localparam int USER_HIT_BOUND = 0;
  localparam int USER_INVALID   = 1;

endpackage

// ===== hw/rtl/affine_quantizer_sat_count.sv =====
// affine quantizer with bound-hit and value counters
//
// usage
//   s_* carries one request per sample: s_tdata = sample_value (signed q16.16),
//   s_tlast = end_of_tensor. m_* returns one result per request: the 16-bit
//   code, the two running totals, a hit-bound and an invalid-parameters flag in
//   m_tuser and the end-of-tensor mark on m_tlast.
//   cfg_we / cfg_index / cfg_data write inv_scale, zero_point, min_code and
//   max_code; write them only while nothing is in flight.
// timing
//   three register stages: input register, product register (one 32x33
//   multiply in front of it), result register (clamp, round and counter update
//   in front of it), in that order; the result register drives m_*. one
//   request per cycle is sustained while m_tready is high.
// stall
//   each stage loads whenever it or the one after it is free, so bubbles close
//   up and a waiting result does not stop new requests until all three stages
//   are full; s_tready then falls combinationally with m_tready.
// reset
//   rst (synchronous) empties the pipe, clears both counters and loads the
//   register defaults (scale 1.0, zero point 0, codes -128 to 127).
module affine_quantizer_sat_count (
  input  logic                                  clk,
  input  logic                                  rst,
  // request side
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [aqsc_pkg::SAMPLE_BITS-1:0]      s_tdata,   // [31:0] sample_value
  input  logic                                  s_tlast,   // end_of_tensor
  // result side
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [15:0] quant_code, [47:16] bound_total, [79:48] value_total
  output logic [aqsc_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  output logic [aqsc_pkg::OUT_USER_BITS-1:0]    m_tuser,   // [0] hit_bound, [1] params_invalid
  output logic                                  m_tlast,   // tensor_done
  // configuration
  input  logic                                  cfg_we,
  input  logic [aqsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [aqsc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import aqsc_pkg::*;

  // configuration registers
  logic [SCALE_BITS-1:0] inv_scale;
  logic signed [15:0]    zero_point;
  logic signed [15:0]    min_code;
  logic signed [15:0]    max_code;

  // pipeline stages
  logic                          s0_valid;
  logic signed [SAMPLE_BITS-1:0] s0_sample;
  logic                          s0_last;
  logic                          s1_valid;
  logic signed [63:0]            s1_prod;
  logic                          s1_last;

  logic [COUNT_BITS-1:0] bound_counter;
  logic [COUNT_BITS-1:0] value_counter;
  logic [COUNT_BITS-1:0] bound_counter_next;
  logic [COUNT_BITS-1:0] value_counter_next;

  logic o_en, s1_en, s0_en, o_load;

  // stage enables: a stage loads when empty or when its successor moves
  assign o_en   = !m_tvalid || m_tready;
  assign s1_en  = !s1_valid || o_en;
  assign s0_en  = !s0_valid || s1_en;
  assign o_load = o_en && s1_valid;
  assign s_tready = s0_en;

  // multiply: signed sample by unsigned scale, product always fits 64 bits
  logic signed [63:0] prod_full;
  assign prod_full = 64'(s0_sample) * 64'($signed({1'b0, inv_scale}));

  // parameter check
  logic invalid;
  assign invalid = (inv_scale == '0) || (min_code >= max_code) ||
                   (zero_point < min_code) || (zero_point > max_code) ||
                   (min_code < CODE_LO) || (max_code > CODE_HI);

  // clamp limits in units of whole codes, compared with the product's top half
  logic signed [16:0] lo_diff, hi_diff;
  logic signed [31:0] p_hi;
  logic [31:0]        p_lo;
  logic               at_lo, at_hi;
  logic signed [32:0] t_hi;
  logic               round_up;
  logic signed [32:0] rounded;
  logic signed [15:0] code;
  logic               hit;

  assign lo_diff = 17'(min_code) - 17'(zero_point);
  assign hi_diff = 17'(max_code) - 17'(zero_point);
  assign p_hi    = s1_prod[63:32];
  assign p_lo    = s1_prod[31:0];

  // p <= lo_diff * 2^32 and p >= hi_diff * 2^32
  assign at_lo = (p_hi < 32'(lo_diff)) || ((p_hi == 32'(lo_diff)) && (p_lo == '0));
  assign at_hi = (p_hi >= 32'(hi_diff));

  // t = p + zero_point * 2^32, fraction unchanged; halves go away from zero
  assign t_hi     = 33'(p_hi) + 33'(zero_point);
  assign round_up = t_hi[32] ? (p_lo > 32'h8000_0000) : p_lo[31];
  assign rounded  = t_hi + 33'(round_up);

  always_comb begin
    if (invalid) begin
      code = '0;
    end else if (at_lo) begin
      code = min_code;
    end else if (at_hi) begin
      code = max_code;
    end else begin
      code = rounded[15:0];
    end
  end

  assign hit = !invalid && ((code == min_code) || (code == max_code));

  // saturating counters, advanced only for valid parameters
  logic [COUNT_BITS-1:0] value_new, bound_new;
  always_comb begin
    value_new = value_counter;
    bound_new = bound_counter;
    if (!invalid && (value_counter != '1)) begin
      value_new = value_counter + COUNT_BITS'(1);
    end
    if (hit && (bound_counter != '1)) begin
      bound_new = bound_counter + COUNT_BITS'(1);
    end
    value_counter_next = s1_last ? '0 : value_new;
    bound_counter_next = s1_last ? '0 : bound_new;
  end

  // totals reported on the result, saturated at the field width
  logic [63:0]           value_wide, bound_wide;
  logic [TOTAL_BITS-1:0] value_total, bound_total;
  assign value_wide  = 64'(value_new);
  assign bound_wide  = 64'(bound_new);
  assign value_total = (value_wide > 64'hFFFF_FFFF) ? '1 : value_wide[TOTAL_BITS-1:0];
  assign bound_total = (bound_wide > 64'hFFFF_FFFF) ? '1 : bound_wide[TOTAL_BITS-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid      <= 1'b0;
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      bound_counter <= '0;
      value_counter <= '0;
      inv_scale     <= INV_SCALE_RST;
      zero_point    <= ZERO_POINT_RST;
      min_code      <= MIN_CODE_RST;
      max_code      <= MAX_CODE_RST;
    end else begin
      if (s0_en) begin
        s0_valid <= s_tvalid;
      end
      if (s1_en) begin
        s1_valid <= s0_valid;
      end
      if (o_en) begin
        m_tvalid <= s1_valid;
      end
      if (o_load) begin
        bound_counter <= bound_counter_next;
        value_counter <= value_counter_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INV_SCALE:  inv_scale  <= cfg_data[SCALE_BITS-1:0];
          REG_ZERO_POINT: zero_point <= cfg_data[15:0];
          REG_MIN_CODE:   min_code   <= cfg_data[15:0];
          REG_MAX_CODE:   max_code   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s0_en) begin
      s0_sample <= s_tdata;
      s0_last   <= s_tlast;
    end
    if (s1_en) begin
      s1_prod <= prod_full;
      s1_last <= s0_last;
    end
    if (o_load) begin
      m_tdata                 <= {value_total, bound_total, code};
      m_tuser[USER_HIT_BOUND] <= hit;
      m_tuser[USER_INVALID]   <= invalid;
      m_tlast                 <= s1_last;
    end
  end

`include "affine_quantizer_sat_count_defines.svh"

  `AQSC_ASSERT_NOW(a_invalid_gives_zero, m_tvalid && m_tuser[USER_INVALID],
                   (m_tdata[15:0] == '0) && !m_tuser[USER_HIT_BOUND],
                   "invalid parameters but code or hit set")
  `AQSC_ASSERT_NOW(a_bound_le_value, m_tvalid, m_tdata[47:16] <= m_tdata[79:48],
                   "bound total exceeds value total")
  `AQSC_ASSERT_NEXT(a_clear_on_last, o_load && s1_last,
                    (bound_counter == '0) && (value_counter == '0),
                    "counters not cleared after end of tensor")
  `AQSC_ASSERT_NOW(a_full_when_blocked, !s_tready, s0_valid && s1_valid && m_tvalid,
                   "input stalled with a free stage")

endmodule

// ===== dv/affine_quantizer_sat_count_test.sv =====
// self-checking testbench for the streaming affine quantizer and its bound-hit counters
`timescale 1ns / 100ps

module affine_quantizer_sat_count_test;
  import aqsc_pkg::*;

  // generous bound on the whole run, far above the slowest legal pace
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     SEGMENTS      = 16;
  localparam int     SEG_ITEMS     = 103;
  localparam longint ONE_Q32       = 64'sh1_0000_0000;
  // idle share in percent: one side idling alone, or both sides idling together
  localparam int     ONE_IDLE_PCT  = 74;
  localparam int     BOTH_IDLE_PCT = 36;

  // who idles during a stretch of random traffic
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one expected result, field for field as it leaves the block
  typedef struct packed {
    logic [CODE_BITS-1:0]  code;
    logic                  hit;
    logic                  bad;
    logic                  done;
    logic [TOTAL_BITS-1:0] bound_total;
    logic [TOTAL_BITS-1:0] value_total;
  } quant_result_t;

  // one row of the directed table: either a register setting or a request
  typedef struct packed {
    logic                   is_cfg;
    logic [SCALE_BITS-1:0]  inv;
    logic [15:0]            zp;
    logic [15:0]            lo;
    logic [15:0]            hi;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
    logic                   chk;
    logic [15:0]            code;
    logic                   hit;
    logic                   bad;
  } stim_row_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [SAMPLE_BITS-1:0]    s_tdata   = '0;   // [31:0] sample_value
  logic                      s_tlast   = 1'b0; // end_of_tensor
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  // [15:0] quant_code, [47:16] bound_total, [79:48] value_total
  logic [OUT_DATA_BITS-1:0]  m_tdata;
  logic [OUT_USER_BITS-1:0]  m_tuser;          // [0] hit_bound, [1] params_invalid
  logic                      m_tlast;          // tensor_done
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // shadow copy of the registers and the two counters
  logic [SCALE_BITS-1:0]   cur_inv_scale  = INV_SCALE_RST;
  logic signed [15:0]      cur_zero_point = ZERO_POINT_RST;
  logic signed [15:0]      cur_min_code   = MIN_CODE_RST;
  logic signed [15:0]      cur_max_code   = MAX_CODE_RST;
  logic [COUNT_BITS-1:0]   bound_count    = '0;
  logic [COUNT_BITS-1:0]   value_count    = '0;

  quant_result_t expected_q[$];
  stim_row_t     rows[$];
  idle_mode_t    idle_mode = IDLE_NONE;

  int fail_count  = 0;
  int cycle_count = 0;
  int n_requests  = 0;
  int n_settings  = 0;
  int n_checked   = 0;
  int n_tensors   = 0;
  int n_invalid   = 0;

  affine_quantizer_sat_count uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // idle share of the current phase
  function automatic int idle_share();
    return (idle_mode == IDLE_BOTH) ? BOTH_IDLE_PCT : ONE_IDLE_PCT;
  endfunction

  // quantise one sample against the shadow registers and advance the shadow counters
  function automatic quant_result_t predict_code(input logic [SAMPLE_BITS-1:0] sample,
                                                 input logic last);
    quant_result_t r;
    logic          bad;
    longint        prod;
    longint        lo_lim;
    longint        hi_lim;
    longint        acc;
    int            code;
    bad = (cur_inv_scale == '0) || (cur_min_code >= cur_max_code) ||
          (cur_zero_point < cur_min_code) || (cur_zero_point > cur_max_code) ||
          (cur_min_code < CODE_LO) || (cur_max_code > CODE_HI);
    code  = 0;
    r.hit = 1'b0;
    if (!bad) begin
      // exact q32.32 product; the limits are the code bounds moved by the zero point
      prod   = longint'($signed(sample)) * longint'({32'd0, cur_inv_scale});
      lo_lim = (longint'(cur_min_code) - longint'(cur_zero_point)) * ONE_Q32;
      hi_lim = (longint'(cur_max_code) - longint'(cur_zero_point)) * ONE_Q32;
      if (prod <= lo_lim) begin
        code = int'(cur_min_code);
      end else if (prod >= hi_lim) begin
        code = int'(cur_max_code);
      end else begin
        // round half away from zero on the magnitude
        acc = prod + longint'(cur_zero_point) * ONE_Q32;
        if (acc >= 0) code = int'((acc + 64'sh8000_0000) >>> 32);
        else code = -int'((64'sh8000_0000 - acc) >>> 32);
      end
      r.hit = (code == int'(cur_min_code)) || (code == int'(cur_max_code));
      if (value_count != '1) value_count++;
      if (r.hit && bound_count != '1) bound_count++;
    end
    r.code        = code[CODE_BITS-1:0];
    r.bad         = bad;
    r.done        = last;
    r.bound_total = bound_count;
    r.value_total = value_count;
    if (last) begin
      bound_count = '0;
      value_count = '0;
    end
    return r;
  endfunction

  function automatic stim_row_t req_row(input logic [SAMPLE_BITS-1:0] sample, input logic last,
                                        input logic chk, input logic [15:0] code,
                                        input logic hit, input logic bad);
    stim_row_t r = '0;
    r.sample = sample;
    r.last   = last;
    r.chk    = chk;
    r.code   = code;
    r.hit    = hit;
    r.bad    = bad;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [SCALE_BITS-1:0] inv, input logic [15:0] zp,
                                        input logic [15:0] lo, input logic [15:0] hi);
    stim_row_t r = '0;
    r.is_cfg = 1'b1;
    r.inv    = inv;
    r.zp     = zp;
    r.lo     = lo;
    r.hi     = hi;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    rows = {rows, r};
  endfunction

  // mixes wide noise, extremes, exact halves and values spread over every magnitude
  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    logic [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 7))
      0, 1: s = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0:       s = 32'h7FFF_FFFF;
          1:       s = 32'h8000_0000;
          2:       s = 32'h0000_0000;
          3:       s = 32'h0000_0001;
          default: s = 32'hFFFF_FFFF;
        endcase
      end
      3:       s = 32'(int'($urandom_range(0, 2047)) - 1024) << 15;  // whole number of halves
      default: s = 32'($signed($urandom) >>> $urandom_range(0, 30));
    endcase
    return s;
  endfunction

  // present one request, wait for the handshake and queue what it should produce
  task automatic send_request(input logic [SAMPLE_BITS-1:0] sample, input logic last,
                              input logic chk, input logic [15:0] code,
                              input logic hit, input logic bad);
    quant_result_t r;
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(0, 99) < idle_share()) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_code(sample, last);
    // typed-in rows pin the code and flags; totals still come from the shadow counters
    if (chk) begin
      r.code = code;
      r.hit  = hit;
      r.bad  = bad;
    end
    expected_q = {expected_q, r};
    n_requests++;
    if (last) n_tensors++;
    if (r.bad) n_invalid++;
  endtask

  // stop sending and let the pipe empty out completely
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers; the short registers get junk in the unused upper half
  task automatic apply_config(input logic [SCALE_BITS-1:0] inv, input logic [15:0] zp,
                              input logic [15:0] lo, input logic [15:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INV_SCALE;
    cfg_data  <= inv;
    @(posedge clk);
    cfg_index <= REG_ZERO_POINT;
    cfg_data  <= {16'($urandom), zp};
    @(posedge clk);
    cfg_index <= REG_MIN_CODE;
    cfg_data  <= {16'($urandom), lo};
    @(posedge clk);
    cfg_index <= REG_MAX_CODE;
    cfg_data  <= {16'($urandom), hi};
    @(posedge clk);
    cfg_we         <= 1'b0;
    cur_inv_scale   = inv;
    cur_zero_point  = zp;
    cur_min_code    = lo;
    cur_max_code    = hi;
    n_settings++;
  endtask

  // mostly usable settings, now and then an invalid one
  task automatic random_config();
    logic [SCALE_BITS-1:0] inv;
    int                    lo;
    int                    hi;
    int                    zp;
    int                    a;
    int                    b;
    case ($urandom_range(0, 11))
      0:       inv = '0;
      1:       inv = '1;
      2, 3:    inv = $urandom;
      default: inv = (32'd1 << $urandom_range(8, 24)) + $urandom_range(0, 255);
    endcase
    a = int'($urandom_range(0, 65535)) - 32768;
    b = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 7))
      0: begin
        lo = int'(CODE_LO);
        hi = int'(CODE_HI);
      end
      1: begin
        lo = -128;
        hi = 127;
      end
      2: begin
        lo = 0;
        hi = 255;
      end
      3: begin
        // min not below max
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
    if (lo < hi && $urandom_range(0, 7) != 0) zp = lo + int'($urandom_range(0, hi - lo));
    else zp = int'($urandom_range(0, 65535)) - 32768;
    apply_config(inv, 16'(zp), 16'(lo), 16'(hi));
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // result side: compare each accepted result with the oldest expectation, then pick ready
  always @(posedge clk) begin : result_check
    quant_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      if (!rst && m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("quant_code", 32'(want.code), 32'(m_tdata[CODE_BITS-1:0]));
          check_field("bound_total", want.bound_total, m_tdata[CODE_BITS +: TOTAL_BITS]);
          check_field("value_total", want.value_total,
                      m_tdata[CODE_BITS+TOTAL_BITS +: TOTAL_BITS]);
          check_field("hit_bound", 32'(want.hit), 32'(m_tuser[USER_HIT_BOUND]));
          check_field("params_invalid", 32'(want.bad), 32'(m_tuser[USER_INVALID]));
          check_field("tensor_done", 32'(want.done), 32'(m_tlast));
          n_checked++;
        end
      end
      if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH)
        m_tready <= ($urandom_range(0, 99) >= idle_share());
      else
        m_tready <= 1'b1;
    end
  end

  initial begin
    stim_row_t row;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight after reset: scale 1.0, zero point 0, codes -128 to 127
    add_row(req_row(32'h0000_0000, 1'b0, 1'b1, 16'd0,     1'b0, 1'b0));
    add_row(req_row(32'h0000_8000, 1'b0, 1'b1, 16'd1,     1'b0, 1'b0)); // +0.5 goes up
    add_row(req_row(32'hFFFF_8000, 1'b0, 1'b1, -16'sd1,   1'b0, 1'b0)); // -0.5 goes down
    add_row(req_row(32'h0000_7FFF, 1'b0, 1'b1, 16'd0,     1'b0, 1'b0)); // just under a half
    add_row(req_row(32'h007E_8000, 1'b0, 1'b1, 16'd127,   1'b1, 1'b0)); // rounds onto max
    add_row(req_row(32'h007F_0000, 1'b0, 1'b1, 16'd127,   1'b1, 1'b0)); // exactly max
    add_row(req_row(32'hFF80_8000, 1'b0, 1'b1, -16'sd128, 1'b1, 1'b0)); // rounds onto min
    add_row(req_row(32'h7FFF_FFFF, 1'b0, 1'b1, 16'd127,   1'b1, 1'b0));
    add_row(req_row(32'h8000_0000, 1'b1, 1'b1, -16'sd128, 1'b1, 1'b0)); // closes tensor
    add_row(req_row(32'h0003_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0));         // counts restart
    // zero scale: invalid, totals frozen but still reported and cleared
    add_row(cfg_row(32'd0, 16'd0, -16'sd128, 16'd127));
    add_row(req_row(32'h1234_5678, 1'b0, 1'b1, 16'd0, 1'b0, 1'b1));
    add_row(req_row(32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 1'b0, 1'b1));
    // widest scale and widest code range
    add_row(cfg_row(32'hFFFF_FFFF, 16'd0, CODE_LO, CODE_HI));
    add_row(req_row(32'h7FFF_FFFF, 1'b0, 1'b1, CODE_HI, 1'b1, 1'b0));
    add_row(req_row(32'h8000_0000, 1'b0, 1'b1, CODE_LO, 1'b1, 1'b0));
    add_row(req_row(32'h0000_0001, 1'b0, 1'b0, '0, 1'b0, 1'b0));
    add_row(req_row(32'hFFFF_FFFF, 1'b1, 1'b0, '0, 1'b0, 1'b0));
    // min not below max
    add_row(cfg_row(32'h0001_0000, 16'd5, 16'd5, 16'd5));
    add_row(req_row(32'h0001_0000, 1'b0, 1'b1, 16'd0, 1'b0, 1'b1));
    // zero point outside the code range
    add_row(cfg_row(32'h0001_0000, 16'd20, -16'sd10, 16'd10));
    add_row(req_row(32'h0000_0000, 1'b0, 1'b1, 16'd0, 1'b0, 1'b1));
    // zero point sitting on the lower bound, then on the upper one
    add_row(cfg_row(32'h0001_0000, -16'sd10, -16'sd10, 16'd10));
    add_row(req_row(32'h0000_0000, 1'b0, 1'b1, -16'sd10, 1'b1, 1'b0));
    add_row(req_row(32'h0001_0000, 1'b0, 1'b1, -16'sd9,  1'b0, 1'b0));
    add_row(cfg_row(32'h0001_0000, 16'd10, -16'sd10, 16'd10));
    add_row(req_row(32'h0000_0000, 1'b1, 1'b1, 16'd10, 1'b1, 1'b0));
    add_row(req_row(32'hFFF6_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0));

    foreach (rows[i]) begin
      row = rows[i];
      if (row.is_cfg) begin
        wait_idle();
        apply_config(row.inv, row.zp, row.lo, row.hi);
      end else begin
        send_request(row.sample, row.last, row.chk, row.code, row.hit, row.bad);
      end
    end
    wait_idle();

    // random traffic: a fresh setting per segment, idling pattern cycling through all four;
    // each segment ends with the sender holding off until every result is back
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_mode = idle_mode_t'(seg % 4);
      if (seg == 0) apply_config('1, 16'd0, CODE_LO, CODE_HI);
      else if (seg == 1) apply_config(32'd1, 16'd0, CODE_LO, CODE_HI);  // tiny scale, ties at -0.5
      else random_config();
      for (int k = 0; k < SEG_ITEMS; k++)
        send_request(random_sample(), $urandom_range(0, 15) == 0, 1'b0, '0, 1'b0, 1'b0);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("%0d requests under %0d register settings, %0d results compared",
             n_requests, n_settings, n_checked);
    $display("%0d tensors closed, %0d results with invalid parameters, %0d mismatches",
             n_tensors, n_invalid, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
